// File: sv/assert_macros.svh
// assertion helpers for the life engine checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define LGE_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("life engine check failed");

// next-cycle implication, sampled on clk, off during rst
`define LGE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("life engine check failed");

`endif

// File: sv/lge_pkg.sv
package lge_pkg;

  // board geometry
  localparam int MAX_ROWS = 256;
  localparam int MAX_COLS = 256;
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ADDR_W   = ROW_W + COL_W;
  localparam int CELLS    = MAX_ROWS * (2 ** COL_W);

  // configuration registers
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'd1;
  localparam logic [CFG_W-1:0]     SIZE_RESET = 9'd256;

  // operation codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_value;
  } in_item_t;

  typedef struct packed {
    logic read_alive;
    logic status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic cell_access;
    logic scan_init;
    logic scan_rd;
    logic swap;
    logic res_load;
  } lge_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       board_empty;
    logic       scan_last;
  } lge_stat_t;

endpackage

// File: sv/lge_ctrl.sv
module lge_ctrl import lge_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  output logic      done,
  input  lge_stat_t stat,
  output lge_cmd_t  cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RESP   = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_DRAIN  = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.op == OP_STEP) begin
          if (stat.board_empty) begin
            state_next = ST_FINISH;
          end else begin
            cmd.scan_init = 1'b1;
            state_next    = ST_SCAN;
          end
        end else begin
          cmd.cell_access = 1'b1;
          state_next      = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd.res_load = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.swap     = 1'b1;
        cmd.res_load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.res_load;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: sv/lge_datapath.sv
module lge_datapath import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  in_item_t             request,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  lge_cmd_t             cmd,
  output lge_stat_t            stat,
  output out_item_t            result
);

  localparam logic [1:0] PH_TOP = 2'd0;
  localparam logic [1:0] PH_MID = 2'd1;
  localparam logic [1:0] PH_BOT = 2'd2;

  // configuration
  logic [CFG_W-1:0] rows_in_use;
  logic [CFG_W-1:0] cols_in_use;
  logic [CFG_W-1:0] nr;
  logic [CFG_W-1:0] nc;

  // captured transaction and bank select
  in_item_t item;
  logic     active_bank;
  logic     coord_ok;

  // scan counters
  logic [ROW_W-1:0] scan_row;
  logic [COL_W:0]   scan_col;
  logic [1:0]       scan_phase;
  logic [ROW_W:0]   row_up;
  logic [ROW_W:0]   src_row;
  logic             src_zero;

  // read tag, registered in the cycle after the address
  logic             tag_valid;
  logic [1:0]       tag_phase;
  logic             tag_zero;
  logic [ROW_W-1:0] tag_row;
  logic [COL_W:0]   tag_col;

  // 3x3 window, bit 0 is the upper row
  logic [1:0] acc;
  logic [2:0] win_l;
  logic [2:0] win_m;
  logic [2:0] win_r;
  logic       src_bit;

  // cell update stage
  logic             emit;
  logic [ROW_W-1:0] emit_row;
  logic [COL_W-1:0] emit_col;
  logic [3:0]       count;
  logic             next_alive;

  // memory ports
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_en;
  logic              wr_bank;
  logic              wr_data;
  logic              rd_a;
  logic              rd_b;
  logic              rd_cur;
  logic              bank_a [CELLS];
  logic              bank_b [CELLS];

  // effective board size
  assign nr = (rows_in_use > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : rows_in_use;
  assign nc = (cols_in_use > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cols_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ROWS) begin
        rows_in_use <= cfg_data;
      end
      if (cfg_index == REG_COLS) begin
        cols_in_use <= cfg_data;
      end
    end
  end

  // transaction capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= request;
    end
  end

  assign coord_ok = (CFG_W'(item.row) < nr) && (CFG_W'(item.col) < nc);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_bank <= 1'b0;
    end else if (cmd.swap) begin
      active_bank <= ~active_bank;
    end
  end

  // scan address: rows r-1, r, r+1 of column c, dead outside the board
  assign row_up   = (ROW_W + 1)'(scan_row) + (ROW_W + 1)'(scan_phase);
  assign src_row  = row_up - (ROW_W + 1)'(1);
  assign src_zero = (row_up == '0) || (CFG_W'(src_row) >= nr) || (CFG_W'(scan_col) >= nc);

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row   <= '0;
      scan_col   <= '0;
      scan_phase <= PH_TOP;
    end else if (cmd.scan_init) begin
      scan_row   <= '0;
      scan_col   <= '0;
      scan_phase <= PH_TOP;
    end else if (cmd.scan_rd) begin
      if (scan_phase == PH_BOT) begin
        scan_phase <= PH_TOP;
        if (CFG_W'(scan_col) == nc) begin
          scan_col <= '0;
          scan_row <= scan_row + ROW_W'(1);
        end else begin
          scan_col <= scan_col + (COL_W + 1)'(1);
        end
      end else begin
        scan_phase <= scan_phase + 2'd1;
      end
    end
  end

  always_comb begin
    stat.op          = item.operation;
    stat.board_empty = (nr == '0) || (nc == '0);
    stat.scan_last   = (scan_phase == PH_BOT) && (CFG_W'(scan_col) == nc)
                       && (CFG_W'(scan_row) == nr - CFG_W'(1));
  end

  // read tag
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= cmd.scan_rd;
    end
    tag_phase <= scan_phase;
    tag_zero  <= src_zero;
    tag_row   <= scan_row;
    tag_col   <= scan_col;
  end

  assign src_bit = tag_zero ? 1'b0 : rd_cur;

  // window shift once a column is complete
  always_ff @(posedge clk) begin
    if (rst) begin
      emit <= 1'b0;
    end else begin
      emit <= tag_valid && (tag_phase == PH_BOT) && (tag_col != '0);
    end
    if (tag_valid) begin
      case (tag_phase)
        PH_TOP: acc[0] <= src_bit;
        PH_MID: acc[1] <= src_bit;
        PH_BOT: begin
          if (tag_col == '0) begin
            win_l <= '0;
            win_m <= '0;
          end else begin
            win_l <= win_m;
            win_m <= win_r;
          end
          win_r <= {src_bit, acc};
        end
        default: acc <= acc;
      endcase
    end
    emit_row <= tag_row;
    emit_col <= COL_W'(tag_col - (COL_W + 1)'(1));
  end

  // b3/s23 rule on the window center
  assign count = 4'(win_l[0]) + 4'(win_l[1]) + 4'(win_l[2])
               + 4'(win_m[0]) + 4'(win_m[2])
               + 4'(win_r[0]) + 4'(win_r[1]) + 4'(win_r[2]);
  assign next_alive = (count == 4'd3) || (win_m[1] && (count == 4'd2));

  // memory port selection
  assign rd_addr = cmd.scan_rd ? {src_row[ROW_W-1:0], scan_col[COL_W-1:0]}
                               : {item.row, item.col};
  assign wr_en   = emit || (cmd.cell_access && (item.operation == OP_WRITE) && coord_ok);
  assign wr_bank = emit ? ~active_bank : active_bank;
  assign wr_addr = emit ? {emit_row, emit_col} : {item.row, item.col};
  assign wr_data = emit ? next_alive : item.cell_value;

  // bank a
  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) begin
      bank_a[wr_addr] <= wr_data;
    end
    rd_a <= bank_a[rd_addr];
  end

  // bank b
  always_ff @(posedge clk) begin
    if (wr_en && wr_bank) begin
      bank_b[wr_addr] <= wr_data;
    end
    rd_b <= bank_b[rd_addr];
  end

  assign rd_cur = active_bank ? rd_b : rd_a;

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      result.read_alive <= (item.operation == OP_READ) && coord_ok && rd_cur;
      if (item.operation == OP_STEP) begin
        result.status <= 1'b0;
      end else if ((item.operation == OP_WRITE) || (item.operation == OP_READ)) begin
        result.status <= ~coord_ok;
      end else begin
        result.status <= 1'b1;
      end
    end
  end

endmodule

// File: sv/life_generation_engine_core.sv
// channel   direction  handshake                 payload
// request   in         start high, busy low      in_item_t (operation, row, col, cell_value)
// result    out        done, one cycle           out_item_t (read_alive, status)
// config    in         cfg_we                    cfg_index, cfg_data
//
// cell write or read: busy through EXEC and RESP, done once back in idle; next start allowed with done
// step: busy through EXEC, SCAN, DRAIN and FINISH, done once back in idle; three reads per column
// step on an empty board: busy through EXEC and FINISH, done once back in idle; banks only swap
// rst is synchronous: controller idle, bank a current, board 256 x 256; cell contents kept
// results cannot be held off; done pulses exactly once per transaction
module life_generation_engine_core import lge_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             request,
  output logic                 done,
  output out_item_t            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  lge_cmd_t  cmd;
  lge_stat_t stat;

  lge_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .stat  (stat),
    .cmd   (cmd)
  );

  lge_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

// File: sv/lge_checker.sv
`include "assert_macros.svh"

module lge_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // an accepted transaction makes the block busy
  `LGE_ASSERT_NEXT(a_accept_busy, start && !busy, busy)

  // a result only shows while the block is free again
  `LGE_ASSERT_NOW(a_done_idle, done, !busy)

  // the block frees up exactly with its result
  `LGE_ASSERT_NOW(a_fall_done, $fell(busy), done)

  // one strobe per transaction
  `LGE_ASSERT_NEXT(a_done_single, done, !done)

endmodule

bind life_generation_engine_core lge_checker u_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);
